/* rtl/skot_pkg.sv */
package skot_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned OWNER_W     = 32;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned S_TDATA_W   = 64;
  localparam int unsigned M_TDATA_W   = 48;
  localparam int unsigned M_PAD_W     = M_TDATA_W - (1 + OWNER_W + 1 + COUNT_W);

  // operation codes carried in s_axis_tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_SET    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_DECIDE,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_INS_RD,
    ST_INS_WR,
    ST_CMP_RD,
    ST_CMP_WR,
    ST_DONE
  } state_e;

  // one table entry
  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [KEY_W-1:0]   key;
  } entry_t;

endpackage

/* rtl/sorted_key_owner_table.sv */
// Sorted key/owner table: up to TABLE_DEPTH (key, owner) pairs held in ascending key order
// in a single-port-write, single-port-read memory with registered read data. One item is
// taken at a time; s_axis_tready is high only while the sequencer is idle. Every step that
// touches the memory presents an address, then uses the registered data. With n pairs held and
// the key found or placed at position p, lookup and owner update scan positions up to p; a
// delete also moves the pairs above p down one place, an insert moves the pairs from p up one
// place, top first, a remove-owner pass reads all n pairs, and an unused mode goes straight to
// the result. After the sequencer finishes, the result is loaded into the output register as
// soon as it is free; an insert into a full table is dropped and answered with status 1.
module sorted_key_owner_table
  import skot_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] key, [63:32] owner
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] hit, [32:1] found_owner, [33] status, [40:34] entry_count, [47:41] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]     aux_q, aux_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [OWNER_W-1:0]   own_q, own_d;
  logic                 hit_q, hit_d;
  logic [OWNER_W-1:0]   found_q, found_d;
  logic                 status_q, status_d;
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  entry_t               mem [TABLE_DEPTH];
  entry_t               rdata_q;
  logic [ADDR_W-1:0]    raddr;
  logic                 mem_we;
  logic [ADDR_W-1:0]    waddr;
  entry_t               wdata;

  logic [CNT_W-1:0]     ptr_nx, ptr_pv;
  logic                 key_lt, key_eq;

  assign ptr_nx = ptr_q + CNT_W'(1);
  assign ptr_pv = ptr_q - CNT_W'(1);

  // shared key comparator
  assign key_lt = rdata_q.key < key_q;
  assign key_eq = rdata_q.key == key_q;

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    aux_q    <= aux_d;
    mode_q   <= mode_d;
    key_q    <= key_d;
    own_q    <= own_d;
    hit_q    <= hit_d;
    found_q  <= found_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
  end

  // sequencer: next state, memory access and result
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    aux_d     = aux_q;
    count_d   = count_q;
    mode_d    = mode_q;
    key_d     = key_q;
    own_d     = own_q;
    hit_d     = hit_q;
    found_d   = found_q;
    status_d  = status_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    mem_we    = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d   = s_axis_tuser;
          key_d    = s_axis_tdata[KEY_W-1:0];
          own_d    = s_axis_tdata[KEY_W +: OWNER_W];
          hit_d    = 1'b0;
          found_d  = '0;
          status_d = 1'b0;
          ptr_d    = '0;
          aux_d    = '0;
          case (s_axis_tuser)
            MODE_SET, MODE_LOOKUP: state_d = ST_SCAN_RD;
            MODE_REMOVE:           state_d = ST_CMP_RD;
            default:               state_d = ST_DONE;
          endcase
        end
      end

      // walk up to the first key not below the search key
      ST_SCAN_RD: begin
        if (ptr_q == count_q) begin
          state_d = ST_DECIDE;
        end else begin
          raddr   = ptr_q[ADDR_W-1:0];
          state_d = ST_SCAN_CK;
        end
      end

      ST_SCAN_CK: begin
        if (key_lt) begin
          ptr_d   = ptr_nx;
          state_d = ST_SCAN_RD;
        end else begin
          hit_d   = key_eq;
          found_d = (key_eq && mode_q == MODE_LOOKUP) ? rdata_q.owner : '0;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d = ST_DONE;
        if (mode_q == MODE_SET) begin
          if (hit_q) begin
            if (own_q != '0) begin
              mem_we = 1'b1;
              waddr  = ptr_q[ADDR_W-1:0];
              wdata  = '{owner: own_q, key: key_q};
            end else begin
              state_d = ST_DEL_RD;
            end
          end else if (own_q != '0) begin
            if (count_q == CNT_W'(TABLE_DEPTH)) begin
              status_d = 1'b1;
            end else begin
              aux_d   = ptr_q;
              ptr_d   = count_q;
              state_d = ST_INS_RD;
            end
          end
        end
      end

      // close the gap left by a deleted pair
      ST_DEL_RD: begin
        if (ptr_nx >= count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end else begin
          raddr   = ptr_nx[ADDR_W-1:0];
          state_d = ST_DEL_WR;
        end
      end

      ST_DEL_WR: begin
        mem_we  = 1'b1;
        waddr   = ptr_q[ADDR_W-1:0];
        wdata   = rdata_q;
        ptr_d   = ptr_nx;
        state_d = ST_DEL_RD;
      end

      // open a slot at the insert position, top entry first
      ST_INS_RD: begin
        if (ptr_q == aux_q) begin
          mem_we  = 1'b1;
          waddr   = ptr_q[ADDR_W-1:0];
          wdata   = '{owner: own_q, key: key_q};
          count_d = count_q + CNT_W'(1);
          state_d = ST_DONE;
        end else begin
          raddr   = ptr_pv[ADDR_W-1:0];
          state_d = ST_INS_WR;
        end
      end

      ST_INS_WR: begin
        mem_we  = 1'b1;
        waddr   = ptr_q[ADDR_W-1:0];
        wdata   = rdata_q;
        ptr_d   = ptr_pv;
        state_d = ST_INS_RD;
      end

      // drop every pair of the owner, keep the rest in order
      ST_CMP_RD: begin
        if (ptr_q == count_q) begin
          count_d = aux_q;
          state_d = ST_DONE;
        end else begin
          raddr   = ptr_q[ADDR_W-1:0];
          state_d = ST_CMP_WR;
        end
      end

      ST_CMP_WR: begin
        if (rdata_q.owner != own_q) begin
          mem_we = 1'b1;
          waddr  = aux_q[ADDR_W-1:0];
          wdata  = rdata_q;
          aux_d  = aux_q + CNT_W'(1);
        end
        ptr_d   = ptr_nx;
        state_d = ST_CMP_RD;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = {M_PAD_W'(0), COUNT_W'(count_q), status_q, found_q, hit_q};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  // the table never holds more pairs than it has entries
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // compaction never writes ahead of the read pointer
  a_cmp_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP_WR) |-> (aux_q <= ptr_q))
    else $error("compaction write pointer passed read pointer");

  // the count moves only when a delete, insert or compaction finishes
  a_count_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == ST_DEL_RD || $past(state_q) == ST_INS_RD ||
       $past(state_q) == ST_CMP_RD))
    else $error("entry count changed outside a table update");

  // a finished result reaches the output only when the register is free
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && m_valid_q && !m_axis_tready) |=> (state_q == ST_DONE))
    else $error("result left sequencer while output was stalled");
`endif

endmodule
